>>> hw/rtl/hfpl_pkg.sv
// Shared types and constants for the heading four-point linearizer.
// No dependencies; imported by every module of the block.
package hfpl_pkg;

  localparam int NUM_POINTS = 4;
  localparam int HEAD_W     = 16;
  localparam int SEG_W      = $clog2(NUM_POINTS);
  localparam int STAT_W     = 2;

  // Fixed-point widths of the datapath
  localparam int SPAN_W  = 17;   // span and segment length, up to 87380
  localparam int OFS_W   = 18;   // signed offset
  localparam int DIVD_W  = 30;   // |offset| * 9000
  localparam int DIVS_W  = 17;   // segment length
  localparam int QUO_W   = 10;   // raw / 100
  localparam int BASE_W  = 15;   // segment * 9000

  localparam logic [HEAD_W-1:0] FULL_SCALE = 16'd35999;
  localparam logic [13:0]       QUARTER    = 14'd9000;

  // floor(x/100) = (x * RECIP_100) >> 23 for any 16-bit x
  localparam logic [16:0] RECIP_100    = 17'd83887;
  localparam int          RECIP_100_SH = 23;
  // floor(y/3) = (y * RECIP_3) >> 19 for any 18-bit y
  localparam logic [17:0] RECIP_3      = 18'd174763;
  localparam int          RECIP_3_SH   = 19;

  typedef logic [HEAD_W-1:0] head_t;
  typedef logic [SEG_W-1:0]  seg_t;
  typedef logic [NUM_POINTS-1:0][HEAD_W-1:0] cal_vec_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_ZERO_LEN = 2'd1,
    STAT_CLAMP    = 2'd2
  } status_t;

  // Per-request info that rides alongside the divider
  typedef struct packed {
    seg_t seg;
    logic neg;
    logic zero_len;
  } side_t;

endpackage

>>> hw/rtl/hfpl_front.sv
// Front pipeline: whole-degree truncation, min/max and span, segment search,
// offset/length and the dividend product. Depends on hfpl_pkg.
module hfpl_front import hfpl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  head_t             raw_heading,
  input  cal_vec_t          cal,
  output logic              dv_valid,
  output logic [DIVD_W-1:0] dv_dividend,
  output logic [DIVS_W-1:0] dv_divisor,
  output side_t             dv_side
);

  // ---- stage 1: reciprocal product, min/max index
  logic [32:0] prod1;
  seg_t        lo01, lo23, hi01, hi23, lo1, hi1;

  logic        s1_v_r;
  head_t       s1_raw_r;
  logic [32:0] s1_prod_r;
  seg_t        s1_lo_r, s1_hi_r;

  assign prod1 = {17'b0, raw_heading} * {16'b0, RECIP_100};

  // ties go to the lower register number
  assign lo01 = (cal[1] < cal[0]) ? 2'd1 : 2'd0;
  assign lo23 = (cal[3] < cal[2]) ? 2'd3 : 2'd2;
  assign lo1  = (cal[lo23] < cal[lo01]) ? lo23 : lo01;
  assign hi01 = (cal[1] > cal[0]) ? 2'd1 : 2'd0;
  assign hi23 = (cal[3] > cal[2]) ? 2'd3 : 2'd2;
  assign hi1  = (cal[hi23] > cal[hi01]) ? hi23 : hi01;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_raw_r  <= raw_heading;
      s1_prod_r <= prod1;
      s1_lo_r   <= lo1;
      s1_hi_r   <= hi1;
    end
  end

  // ---- stage 2: whole degrees, span product
  logic [QUO_W-1:0] quot2;
  head_t            whole2;
  logic [17:0]      diff4;
  logic [35:0]      sprod2;

  logic        s2_v_r;
  head_t       s2_raw_r, s2_whole_r;
  logic [35:0] s2_sprod_r;
  seg_t        s2_lo_r, s2_hi_r;

  assign quot2  = s1_prod_r[RECIP_100_SH +: QUO_W];
  assign whole2 = HEAD_W'({6'b0, quot2} * 16'd100);
  assign diff4  = {cal[s1_hi_r] - cal[s1_lo_r], 2'b00};
  assign sprod2 = {18'b0, diff4} * {18'b0, RECIP_3};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_raw_r   <= s1_raw_r;
      s2_whole_r <= whole2;
      s2_sprod_r <= sprod2;
      s2_lo_r    <= s1_lo_r;
      s2_hi_r    <= s1_hi_r;
    end
  end

  // ---- stage 3: segment search from the smallest point
  seg_t seg3;

  logic              s3_v_r;
  head_t             s3_whole_r;
  seg_t              s3_seg_r;
  logic [SPAN_W-1:0] s3_span_r;

  always_comb begin
    seg_t pos;
    seg_t nxt;
    logic found;
    seg3  = s2_hi_r;   // wrap segment when nothing matches
    found = 1'b0;
    for (int i = 0; i < NUM_POINTS - 1; i++) begin
      pos = s2_lo_r + SEG_W'(i);
      nxt = pos + 1'b1;
      if (!found && (s2_whole_r >= cal[pos]) && (s2_raw_r < cal[nxt])) begin
        seg3  = pos;
        found = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_whole_r <= s2_whole_r;
      s3_seg_r   <= seg3;
      s3_span_r  <= s2_sprod_r[RECIP_3_SH +: SPAN_W];
    end
  end

  // ---- stage 4: offset and length, span added when negative
  seg_t                    nxt4;
  logic signed [OFS_W-1:0] ofs_raw4, len_raw4, ofs4, len4;

  logic                    s4_v_r;
  logic signed [OFS_W-1:0] s4_ofs_r;
  logic [DIVS_W-1:0]       s4_len_r;
  seg_t                    s4_seg_r;

  assign nxt4     = s3_seg_r + 1'b1;
  assign ofs_raw4 = {2'b0, s3_whole_r} - {2'b0, cal[s3_seg_r]};
  assign len_raw4 = {2'b0, cal[nxt4]} - {2'b0, cal[s3_seg_r]};
  assign ofs4     = ofs_raw4[OFS_W-1] ? ofs_raw4 + {1'b0, s3_span_r} : ofs_raw4;
  assign len4     = len_raw4[OFS_W-1] ? len_raw4 + {1'b0, s3_span_r} : len_raw4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (en) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_ofs_r <= ofs4;
      s4_len_r <= len4[DIVS_W-1:0];   // never negative after the span fix
      s4_seg_r <= s3_seg_r;
    end
  end

  // ---- stage 5: |offset| * 9000
  logic [OFS_W-1:0] mag5;
  logic [31:0]      dprod5;

  logic              s5_v_r;
  logic [DIVD_W-1:0] s5_divd_r;
  logic [DIVS_W-1:0] s5_divs_r;
  side_t             s5_side_r;

  assign mag5   = s4_ofs_r[OFS_W-1] ? OFS_W'(-s4_ofs_r) : OFS_W'(s4_ofs_r);
  assign dprod5 = {14'b0, mag5} * {18'b0, QUARTER};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (en) begin
      s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_divd_r          <= dprod5[DIVD_W-1:0];
      s5_divs_r          <= s4_len_r;
      s5_side_r.seg      <= s4_seg_r;
      s5_side_r.neg      <= s4_ofs_r[OFS_W-1];
      s5_side_r.zero_len <= (s4_len_r == '0);
    end
  end

  assign dv_valid    = s5_v_r;
  assign dv_dividend = s5_divd_r;
  assign dv_divisor  = s5_divs_r;
  assign dv_side     = s5_side_r;

endmodule

>>> hw/rtl/hfpl_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on hfpl_pkg.
module hfpl_div import hfpl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [DIVD_W-1:0] in_dividend,
  input  logic [DIVS_W-1:0] in_divisor,
  input  side_t             in_side,
  output logic              out_valid,
  output logic [DIVD_W-1:0] out_quotient,
  output side_t             out_side
);

  logic              v_r    [DIVD_W];
  logic [DIVD_W-1:0] dq_r   [DIVD_W];   // dividend bits shift out, quotient bits in
  logic [DIVS_W-1:0] rem_r  [DIVD_W];
  logic [DIVS_W-1:0] dvs_r  [DIVD_W];
  side_t             side_r [DIVD_W];

  for (genvar k = 0; k < DIVD_W; k++) begin : g_stage
    logic              v_i;
    logic [DIVD_W-1:0] dq_i;
    logic [DIVS_W-1:0] rem_i, dvs_i;
    side_t             side_i;
    logic [DIVS_W:0]   trial;
    logic              take;

    if (k == 0) begin : g_head
      assign v_i    = in_valid;
      assign dq_i   = in_dividend;
      assign rem_i  = '0;
      assign dvs_i  = in_divisor;
      assign side_i = in_side;
    end else begin : g_body
      assign v_i    = v_r[k-1];
      assign dq_i   = dq_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign dvs_i  = dvs_r[k-1];
      assign side_i = side_r[k-1];
    end

    assign trial = {rem_i, dq_i[DIVD_W-1]};
    assign take  = (trial >= {1'b0, dvs_i});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= take ? DIVS_W'(trial - {1'b0, dvs_i}) : trial[DIVS_W-1:0];
        dq_r[k]   <= {dq_i[DIVD_W-2:0], take};
        dvs_r[k]  <= dvs_i;
        side_r[k] <= side_i;
      end
    end
  end

  assign out_valid    = v_r[DIVD_W-1];
  assign out_quotient = dq_r[DIVD_W-1];
  assign out_side     = side_r[DIVD_W-1];

`ifndef SYNTHESIS
  // remainder left at the end is always below a nonzero divisor
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[DIVD_W-1] && (dvs_r[DIVD_W-1] != '0)) |-> (rem_r[DIVD_W-1] < dvs_r[DIVD_W-1]))
    else $error("divider remainder not reduced");
`endif

endmodule

>>> hw/rtl/heading_four_point_linearizer_core.sv
// Top level of the heading four-point linearizer: calibration registers,
// front pipeline, divider and output clamp. Depends on hfpl_pkg, hfpl_front, hfpl_div.
//
//  channel  direction  handshake           payload
//  in_      request in in_valid / in_stall  in_raw_heading[15:0]
//  out_     request out out_valid/out_stall out_true_heading[15:0], out_segment_index[1:0],
//                                           out_status[1:0]
//  cfg_     write      cfg_we              cfg_index[1:0], cfg_wdata[15:0]
//
// Throughput is one request per cycle unless the output is stalled; out_valid rises when
// a request reaches the last of 36 register stages (five front, 30 divider, one output),
// the first loaded at the accepting edge; the divider's bit-per-stage chain sets the depth.
// Reset (rst_n low, synchronous) clears all valid bits and the calibration points.
// A stalled output freezes the whole pipe in place; in_stall is high exactly then,
// so nothing is dropped or repeated, and bubbles stay where they are while a result waits.
module heading_four_point_linearizer_core import hfpl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // request in
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [HEAD_W-1:0] in_raw_heading,
  // request out
  output logic              out_valid,
  input  logic              out_stall,
  output logic [HEAD_W-1:0] out_true_heading,
  output logic [SEG_W-1:0]  out_segment_index,
  output logic [STAT_W-1:0] out_status,
  // configuration
  input  logic              cfg_we,
  input  logic [SEG_W-1:0]  cfg_index,
  input  logic [HEAD_W-1:0] cfg_wdata
);

  // Calibration points. Written only while the pipe is empty, so every stage reads them
  // directly; the user must keep to this, since the block does not enforce it.
  cal_vec_t cal_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else if (cfg_we) begin
      cal_r[cfg_index] <= cfg_wdata;
    end
  end

  // Global advance: everything moves unless a finished result is held.
  logic en;
  logic out_valid_r;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  logic              dv_valid;
  logic [DIVD_W-1:0] dv_dividend;
  logic [DIVS_W-1:0] dv_divisor;
  side_t             dv_side;

  hfpl_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (in_valid),
    .raw_heading (in_raw_heading),
    .cal         (cal_r),
    .dv_valid    (dv_valid),
    .dv_dividend (dv_dividend),
    .dv_divisor  (dv_divisor),
    .dv_side     (dv_side)
  );

  logic              q_valid;
  logic [DIVD_W-1:0] q_quotient;
  side_t             q_side;

  hfpl_div u_div (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_valid     (dv_valid),
    .in_dividend  (dv_dividend),
    .in_divisor   (dv_divisor),
    .in_side      (dv_side),
    .out_valid    (q_valid),
    .out_quotient (q_quotient),
    .out_side     (q_side)
  );

  // Output stage: seg*9000 +/- quotient, then clamp to 0..35999; zero length gives 0.
  logic [BASE_W-1:0] base;
  logic [DIVD_W:0]   sum;
  head_t             heading_nxt;
  status_t           status_nxt;

  assign base = BASE_W'({13'b0, q_side.seg} * BASE_W'(QUARTER));
  assign sum  = {16'b0, base} + {1'b0, q_quotient};

  always_comb begin
    heading_nxt = '0;
    status_nxt  = STAT_OK;
    if (q_side.zero_len) begin
      status_nxt = STAT_ZERO_LEN;
    end else if (q_side.neg) begin
      // negative offset: quotient is subtracted, truncated toward zero
      if ({15'b0, base} < q_quotient) begin
        status_nxt = STAT_CLAMP;
      end else begin
        heading_nxt = HEAD_W'(base - q_quotient[BASE_W-1:0]);
      end
    end else if (sum > {15'b0, FULL_SCALE}) begin
      heading_nxt = FULL_SCALE;
      status_nxt  = STAT_CLAMP;
    end else begin
      heading_nxt = sum[HEAD_W-1:0];
    end
  end

  head_t   out_heading_r;
  seg_t    out_seg_r;
  status_t out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_heading_r <= heading_nxt;
      out_seg_r     <= q_side.seg;
      out_status_r  <= status_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_true_heading  = out_heading_r;
  assign out_segment_index = out_seg_r;
  assign out_status        = out_status_r;

`ifndef SYNTHESIS
  // zero-length segment always reports heading 0
  a_zero_len_heading: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == STAT_ZERO_LEN)) |-> (out_true_heading == '0))
    else $error("zero-length segment with nonzero heading");

  // clamp keeps every result in range
  a_heading_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_true_heading <= FULL_SCALE))
    else $error("heading above full scale");

  // a quotient leaving the divider while the pipe advances lands in the output
  a_quotient_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && !in_stall) |=> out_valid)
    else $error("finished quotient lost before output");
`endif

endmodule

>>> tb/tb.sv
// Self-checking bench for heading_four_point_linearizer_core: drives raw headings
// through a valid/stall handshake and checks every result against a local predictor.
// Depends on hfpl_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb;
  import hfpl_pkg::*;

  localparam int NUM_PHASES     = 13;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 40;   // pipe is 36 deep
  localparam int REPORT_LIMIT   = 10;

  // one expected result of the block
  typedef struct packed {
    head_t   heading;
    seg_t    seg;
    status_t status;
  } heading_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [HEAD_W-1:0] in_raw_heading = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [HEAD_W-1:0] out_true_heading;
  logic [SEG_W-1:0]  out_segment_index;
  logic [STAT_W-1:0] out_status;
  logic              cfg_we = 1'b0;
  logic [SEG_W-1:0]  cfg_index = '0;
  logic [HEAD_W-1:0] cfg_wdata = '0;

  head_t           cal_copy [NUM_POINTS];   // calibration points as written
  head_t           heading_q [$];           // raw headings waiting to be sent
  heading_result_t expected_q [$];          // predicted results, oldest first
  heading_result_t want;
  int              send_idle_pct  = 0;
  int              recv_stall_pct = 0;
  int              fault_count    = 0;
  int              quiet_cycles   = 0;

  heading_four_point_linearizer_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_raw_heading    (in_raw_heading),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_true_heading  (out_true_heading),
    .out_segment_index (out_segment_index),
    .out_status        (out_status),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always #4 clk = ~clk;

  // Piecewise linear map of one raw heading, exact in 64-bit signed math.
  function automatic heading_result_t linearize_heading(head_t raw);
    longint          whole, span, offset, seg_len, corrected;
    int              lo, hi, seg, pos, nxt, i;
    heading_result_t r;
    whole = (longint'(raw) / 100) * 100;
    lo = 0;
    hi = 0;
    // ties: lowest-numbered point wins both ways
    for (i = 1; i < NUM_POINTS; i++) begin
      if (cal_copy[i] < cal_copy[lo]) lo = i;
      if (cal_copy[i] > cal_copy[hi]) hi = i;
    end
    // walk three segments from the smallest point; default is the wrap segment
    seg = hi;
    pos = lo;
    for (i = 1; i < NUM_POINTS; i++) begin
      nxt = (pos + 1) % NUM_POINTS;
      if (whole >= longint'(cal_copy[pos]) && longint'(raw) < longint'(cal_copy[nxt])) begin
        seg = pos;
        break;
      end
      pos = nxt;
    end
    span    = ((longint'(cal_copy[hi]) - longint'(cal_copy[lo])) * 4) / 3;
    offset  = whole - longint'(cal_copy[seg]);
    if (offset < 0) offset += span;
    seg_len = longint'(cal_copy[(seg + 1) % NUM_POINTS]) - longint'(cal_copy[seg]);
    if (seg_len < 0) seg_len += span;
    r.seg    = seg_t'(seg);
    r.status = STAT_OK;
    if (seg_len == 0) begin
      r.heading = '0;
      r.status  = STAT_ZERO_LEN;
    end else begin
      corrected = longint'(seg) * longint'(QUARTER)
                + (offset * longint'(QUARTER)) / seg_len;
      if (corrected < 0) begin
        corrected = 0;
        r.status  = STAT_CLAMP;
      end else if (corrected > longint'(FULL_SCALE)) begin
        corrected = longint'(FULL_SCALE);
        r.status  = STAT_CLAMP;
      end
      r.heading = head_t'(corrected);
    end
    return r;
  endfunction

  // Request driver: predicts each request as it is accepted, then offers the next
  // one unless it idles this cycle. A stalled request is held unchanged.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) expected_q.push_back(linearize_heading(in_raw_heading));
      if (heading_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid       <= 1'b1;
        in_raw_heading <= heading_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor: compares each accepted result with the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          if (fault_count < REPORT_LIMIT)
            $display("unexpected result: heading %0d seg %0d status %0d",
                     out_true_heading, out_segment_index, out_status);
          fault_count++;
        end else begin
          want = expected_q.pop_front();
          if (out_true_heading !== want.heading || out_segment_index !== want.seg ||
              out_status !== want.status) begin
            if (fault_count < REPORT_LIMIT)
              $display("mismatch: heading %0d/%0d seg %0d/%0d status %0d/%0d (exp/got)",
                       want.heading, out_true_heading, want.seg, out_segment_index,
                       want.status, out_status);
            fault_count++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: ends the run after too long without any handshake or write.
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  // Stimulus: each phase writes a calibration set while the pipe is empty,
  // picks an idle mode, queues directed then random headings and drains.
  initial begin
    int unsigned cal_plan [NUM_POINTS];
    head_t       directed_q [$];
    int          p, i, n, kind, base, a, b, v, pick;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    for (p = 0; p < NUM_PHASES; p++) begin
      directed_q.delete();
      case (p)
        // evenly spread points: segment edges, wrap, clamp high, out-of-range input
        0: begin
          cal_plan = '{1000, 10000, 19000, 28000};
          directed_q = '{16'd0, 16'd999, 16'd1000, 16'd1050, 16'd9999, 16'd10000,
                         16'd27999, 16'd28000, 16'd35999, 16'd36000, 16'hFFFF,
                         16'hAAAA, 16'h5555};
        end
        // all points zero: every segment has zero length
        1: begin
          cal_plan = '{0, 0, 0, 0};
          directed_q = '{16'd0, 16'd12345};
        end
        // all points at the top of the register range
        2: begin
          cal_plan = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
          directed_q = '{16'hFFFF, 16'd0};
        end
        // tight cluster: offset stays negative after span, clamps to zero
        3: begin
          cal_plan = '{3000, 3300, 3600, 3900};
          directed_q = '{16'd0, 16'd3450};
        end
        // tied points: lowest register wins for both smallest and largest
        4: begin
          cal_plan = '{5000, 5000, 20000, 20000};
          directed_q = '{16'd10000, 16'd25000, 16'd0};
        end
        default: begin
          kind = $urandom_range(9);
          a = $urandom_range(35999);
          b = $urandom_range(35999);
          base = $urandom_range(35999);
          for (i = 0; i < NUM_POINTS; i++) begin
            if (kind <= 5)        // realistic quarter turns with jitter
              cal_plan[i] = (base + i * 9000 + $urandom_range(3000) + 36000 - 1500) % 36000;
            else if (kind == 6)
              cal_plan[i] = $urandom_range(35999);
            else if (kind == 7)
              cal_plan[i] = $urandom_range(16'hFFFF);
            else
              cal_plan[i] = $urandom_range(1) ? a : b;
          end
        end
      endcase

      for (i = 0; i < NUM_POINTS; i++) begin
        @(posedge clk);
        cfg_we      <= 1'b1;
        cfg_index   <= seg_t'(i);
        cfg_wdata   <= head_t'(cal_plan[i]);
        cal_copy[i] = head_t'(cal_plan[i]);
      end
      @(posedge clk);
      cfg_we <= 1'b0;

      @(negedge clk);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      foreach (directed_q[i]) heading_q.push_back(directed_q[i]);
      n = (p < 5) ? 30 : 60;
      for (i = 0; i < n; i++) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          v = $urandom_range(35999);
        end else if (pick < 85) begin
          // close to a calibration point, where segment edges sit
          v = int'(cal_copy[$urandom_range(NUM_POINTS - 1)]) + $urandom_range(300) - 150;
          if (v < 0) v = 0;
          if (v > 16'hFFFF) v = 16'hFFFF;
        end else begin
          v = $urandom_range(16'hFFFF);
        end
        heading_q.push_back(head_t'(v));
      end

      @(negedge clk);
      while (heading_q.size() != 0 || in_valid || expected_q.size() != 0)
        @(negedge clk);
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fault_count == 0 && expected_q.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
